@@ design/bmpc_pkg.sv @@
// Package for the blind position controller: item types, command and
// motion codes, and the round-to-five helper. No dependencies.
package bmpc_pkg;

  localparam int unsigned PCT_W   = 7;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned NUMER_W = 23;  // elapsed * 100 fits here
  localparam int unsigned QUOT_W  = 7;   // quotient never exceeds 100

  localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_STEP     = 7'd5;
  localparam logic [PCT_W-1:0]  ROUND_DN_MAX = 7'd2;
  localparam logic [TIME_W-1:0] TRAVEL_RESET = 16'd10000;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MOT_STOPPED  = 2'd0,
    MOT_RAISING  = 2'd1,
    MOT_LOWERING = 2'd2,
    MOT_HALTED   = 2'd3
  } motion_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_DIV
  } seq_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic       level;
  } bmpc_in_t;

  typedef struct packed {
    logic [PCT_W-1:0] position_percent;
    logic [1:0]       motion_state;
    logic             state_changed;
  } bmpc_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bmpc_div_status_t;

  // Round a value of 0..100 to the nearest multiple of five; remainders
  // up to two go down. Quotient by five through a reciprocal multiply.
  function automatic logic [PCT_W-1:0] round5(input logic [PCT_W-1:0] p);
    logic [14:0]      prod;
    logic [PCT_W-1:0] q;
    logic [PCT_W-1:0] r;
    prod = 15'(p) * 15'd205;
    q    = PCT_W'(prod[14:10]);
    r    = p - ((q << 2) + q);
    if (r <= ROUND_DN_MAX) begin
      return p - r;
    end else begin
      return p + (PCT_STEP - r);
    end
  endfunction

endpackage

@@ design/bmpc_div.sv @@
// Iterative restoring divider: one compare and subtract per cycle.
// Depends on bmpc_pkg.
module bmpc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bmpc_pkg::NUMER_W-1:0]  numer_i,
  input  logic [bmpc_pkg::TIME_W-1:0]   denom_i,
  output bmpc_pkg::bmpc_div_status_t    status_o,
  output logic [bmpc_pkg::QUOT_W-1:0]   quot_o
);
  import bmpc_pkg::*;

  localparam int unsigned DEN_W = TIME_W + QUOT_W - 1;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [NUMER_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]    den_q, den_d;
  logic [QUOT_W-1:0]   quo_q, quo_d;
  logic [NUMER_W-1:0]  den_ext;
  logic                fits;

  assign den_ext = NUMER_W'(den_q);
  assign fits    = rem_q >= den_ext;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'(QUOT_W - 1);
      rem_d  = numer_i;
      den_d  = {denom_i, {(QUOT_W-1){1'b0}}};
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d        = rem_q - den_ext;
        quo_d[cnt_q] = 1'b1;
      end
      den_d = den_q >> 1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quo_q;

endmodule

@@ design/blind_motor_position_controller_core.sv @@
// Blind position controller: button state machine and position estimate.
// Depends on bmpc_pkg and bmpc_div.
//
// Button items (cmd 1 or 2), unused codes and ticks while stopped or halted
// are handled in the accept cycle; the result appears in the output register
// on the next cycle. A tick while raising or lowering passes through the
// accept cycle, which advances elapsed, a load step that forms elapsed*100 and
// loads the divider, seven compare-subtract steps (one per quotient bit) and a
// final step to clamp, round and load the result. The block takes the next item once it
// is back in idle and the output register is free or being read. Write the
// travel time only while no item is in flight, never in the cycle that an
// item is accepted; a value of zero acts as one millisecond.
module blind_motor_position_controller_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bmpc_pkg::TIME_W-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bmpc_pkg::bmpc_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bmpc_pkg::bmpc_out_t               out_data_o
);
  import bmpc_pkg::*;

  seq_e                seq_q, seq_d;
  motion_e             motion_q, motion_d;
  logic [TIME_W-1:0]   travel_q, travel_d;
  logic [TIME_W-1:0]   elapsed_q, elapsed_d;
  logic [PCT_W-1:0]    start_q, start_d;
  logic [PCT_W-1:0]    shown_q, shown_d;
  logic                up_q, up_d;
  logic                down_q, down_d;
  logic                out_valid_q, out_valid_d;
  bmpc_out_t           out_q, out_d;

  logic [TIME_W-1:0]   t_eff;
  logic                accept;
  logic                moving;
  logic                up_n, down_n;
  motion_e             motion_btn;
  logic                leave_move;
  logic [NUMER_W-1:0]  numer;
  logic                div_start;
  bmpc_div_status_t    div_st;
  logic [QUOT_W-1:0]   part;
  logic [PCT_W:0]      rise_sum;
  logic [PCT_W-1:0]    total;

  assign t_eff  = (travel_q == '0) ? TIME_W'(1) : travel_q;
  assign in_ready_o = (seq_q == SEQ_IDLE) && (!out_valid_q || out_ready_i);
  assign accept = in_valid_i && in_ready_o;
  assign moving = (motion_q == MOT_RAISING) || (motion_q == MOT_LOWERING);

  // elapsed * 100 as a sum of shifted copies
  assign numer = NUMER_W'({elapsed_q, 6'b0}) + NUMER_W'({elapsed_q, 5'b0})
               + NUMER_W'({elapsed_q, 2'b0});
  assign div_start = (seq_q == SEQ_LOAD);

  bmpc_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .numer_i  (numer),
    .denom_i  (t_eff),
    .status_o (div_st),
    .quot_o   (part)
  );

  // Button levels after this item, then the motion state they give.
  always_comb begin
    up_n   = up_q;
    down_n = down_q;
    if (in_data_i.cmd == CMD_UP) begin
      up_n = in_data_i.level;
    end
    if (in_data_i.cmd == CMD_DOWN) begin
      down_n = in_data_i.level;
    end
    motion_btn = motion_q;
    leave_move = 1'b0;
    case (motion_q)
      MOT_STOPPED: begin
        if (up_n && !down_n) begin
          motion_btn = MOT_RAISING;
        end else if (!up_n && down_n) begin
          motion_btn = MOT_LOWERING;
        end
      end
      MOT_RAISING: begin
        if (!up_n && !down_n) begin
          motion_btn = MOT_STOPPED;
          leave_move = 1'b1;
        end else if (!up_n && down_n) begin
          motion_btn = MOT_HALTED;
          leave_move = 1'b1;
        end
      end
      MOT_LOWERING: begin
        if (!up_n && !down_n) begin
          motion_btn = MOT_STOPPED;
          leave_move = 1'b1;
        end else if (up_n && !down_n) begin
          motion_btn = MOT_HALTED;
          leave_move = 1'b1;
        end
      end
      default: begin
        if (!up_n && !down_n) begin
          motion_btn = MOT_STOPPED;
        end
      end
    endcase
  end

  // Clamp the estimate formed from the divider result; round5 rounds it when it is loaded.
  always_comb begin
    rise_sum = {1'b0, start_q} + {1'b0, part};
    if (motion_q == MOT_RAISING) begin
      total = (rise_sum >= {1'b0, PCT_FULL}) ? PCT_FULL : rise_sum[PCT_W-1:0];
    end else begin
      total = (part > start_q) ? '0 : start_q - part;
    end
  end

  always_comb begin
    seq_d       = seq_q;
    motion_d    = motion_q;
    travel_d    = cfg_we_i ? cfg_wdata_i : travel_q;
    elapsed_d   = elapsed_q;
    start_d     = start_q;
    shown_d     = shown_q;
    up_d        = up_q;
    down_d      = down_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          case (in_data_i.cmd)
            CMD_TICK: begin
              if (moving) begin
                elapsed_d = (elapsed_q >= t_eff) ? t_eff : elapsed_q + TIME_W'(1);
                seq_d     = SEQ_LOAD;
              end else begin
                out_valid_d = 1'b1;
                out_d       = '{shown_q, motion_q, 1'b0};
              end
            end
            CMD_UP, CMD_DOWN: begin
              up_d     = up_n;
              down_d   = down_n;
              motion_d = motion_btn;
              if ((motion_q == MOT_STOPPED) && (motion_btn != MOT_STOPPED)) begin
                elapsed_d = '0;
              end
              if (leave_move) begin
                start_d = shown_q;
              end
              out_valid_d = 1'b1;
              out_d       = '{shown_q, motion_btn, motion_btn != motion_q};
            end
            default: begin
              out_valid_d = 1'b1;
              out_d       = '{shown_q, motion_q, 1'b0};
            end
          endcase
        end
      end
      SEQ_LOAD: begin
        seq_d = SEQ_DIV;
      end
      SEQ_DIV: begin
        if (div_st.done) begin
          shown_d     = round5(total);
          out_valid_d = 1'b1;
          out_d       = '{round5(total), motion_q, 1'b0};
          seq_d       = SEQ_IDLE;
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      motion_q    <= MOT_STOPPED;
      travel_q    <= TRAVEL_RESET;
      elapsed_q   <= '0;
      start_q     <= '0;
      shown_q     <= '0;
      up_q        <= 1'b0;
      down_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      motion_q    <= motion_d;
      travel_q    <= travel_d;
      elapsed_q   <= elapsed_d;
      start_q     <= start_d;
      shown_q     <= shown_d;
      up_q        <= up_d;
      down_q      <= down_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_shown_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shown_q <= PCT_FULL)
    else $error("shown position above full travel");

  a_div_only_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_DIV) |-> ((motion_q == MOT_RAISING) || (motion_q == MOT_LOWERING)))
    else $error("divider running while not moving");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (seq_q == SEQ_DIV))
    else $error("divider finished outside the divide step");

  a_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (seq_q == SEQ_DIV))
    else $error("divider busy outside the divide step");

  a_button_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.cmd == CMD_UP || in_data_i.cmd == CMD_DOWN)) |=> out_valid_q)
    else $error("button item gave no result");
`endif

endmodule

@@ dv/bmpc_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for blind_motor_position_controller_core: mirrors the button
// state machine and the position estimate, and compares every result item.
// Depends on bmpc_pkg.
module bmpc_result_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bmpc_pkg::TIME_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  bmpc_pkg::bmpc_in_t           in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  bmpc_pkg::bmpc_out_t          out_data_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  pending_o
);
  import bmpc_pkg::*;

  logic [TIME_W-1:0] travel_ms;
  motion_e           motion;
  logic [PCT_W-1:0]  start_pct;
  logic [PCT_W-1:0]  shown_pct;
  logic [TIME_W-1:0] elapsed_ms;
  logic              up_held;
  logic              down_held;
  bmpc_out_t         blind_status_q[$];
  int unsigned       mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_cnt++;
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic void follow_buttons();
    case (motion)
      MOT_STOPPED: begin
        if (up_held && !down_held) begin
          motion     = MOT_RAISING;
          elapsed_ms = '0;
        end else if (!up_held && down_held) begin
          motion     = MOT_LOWERING;
          elapsed_ms = '0;
        end
      end
      MOT_RAISING: begin
        if (!up_held) begin
          // latch the shown position as the start of the next move
          start_pct = shown_pct;
          motion    = down_held ? MOT_HALTED : MOT_STOPPED;
        end
      end
      MOT_LOWERING: begin
        if (!down_held) begin
          start_pct = shown_pct;
          motion    = up_held ? MOT_HALTED : MOT_STOPPED;
        end
      end
      default: begin
        if (!up_held && !down_held) begin
          motion = MOT_STOPPED;
        end
      end
    endcase
  endfunction

  function automatic bmpc_out_t step_blind(input bmpc_in_t item);
    motion_e     prior;
    int unsigned span;
    int unsigned part;
    int unsigned total;
    int unsigned rem;
    bmpc_out_t   res;
    prior = motion;
    span  = (travel_ms == '0) ? 1 : int'(travel_ms);
    case (cmd_e'(item.cmd))
      CMD_TICK: begin
        if (motion == MOT_RAISING || motion == MOT_LOWERING) begin
          if (elapsed_ms >= span) begin
            elapsed_ms = TIME_W'(span);
          end else begin
            elapsed_ms = elapsed_ms + 1'b1;
          end
          part = (int'(elapsed_ms) * int'(PCT_FULL)) / span;
          if (motion == MOT_RAISING) begin
            total = int'(start_pct) + part;
            if (total > PCT_FULL) begin
              total = PCT_FULL;
            end
          end else begin
            total = (part > start_pct) ? 0 : int'(start_pct) - part;
          end
          // round to the nearest step, small remainders go down
          rem = total % PCT_STEP;
          shown_pct = (rem <= ROUND_DN_MAX) ? PCT_W'(total - rem)
                                             : PCT_W'(total + PCT_STEP - rem);
        end
      end
      CMD_UP: begin
        up_held = item.level;
        follow_buttons();
      end
      CMD_DOWN: begin
        down_held = item.level;
        follow_buttons();
      end
      default: begin
      end
    endcase
    res.position_percent = shown_pct;
    res.motion_state     = motion;
    res.state_changed    = (motion != prior);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bmpc_out_t want;
    if (!rst_ni) begin
      travel_ms  = TRAVEL_RESET;
      motion     = MOT_STOPPED;
      start_pct  = '0;
      shown_pct  = '0;
      elapsed_ms = '0;
      up_held    = 1'b0;
      down_held  = 1'b0;
      blind_status_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        travel_ms = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (blind_status_q.size() == 0) begin
          report_mismatch("unexpected result item, position",
                          out_data_i.position_percent, 0);
        end else begin
          want = blind_status_q.pop_front();
          if (out_data_i.position_percent !== want.position_percent) begin
            report_mismatch("position_percent", out_data_i.position_percent,
                            want.position_percent);
          end
          if (out_data_i.motion_state !== want.motion_state) begin
            report_mismatch("motion_state", out_data_i.motion_state,
                            want.motion_state);
          end
          if (out_data_i.state_changed !== want.state_changed) begin
            report_mismatch("state_changed", out_data_i.state_changed,
                            want.state_changed);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        blind_status_q.push_back(step_blind(in_data_i));
      end
      pending_o <= blind_status_q.size();
    end
  end

endmodule

@@ dv/blind_motor_position_controller_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for blind_motor_position_controller_core: drives button, tick
// and unused-code items and travel-time writes, and gives the verdict.
// Depends on bmpc_pkg, the core and bmpc_result_checker.
module blind_motor_position_controller_core_tb;
  import bmpc_pkg::*;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 130;
  localparam int unsigned MAX_BURST       = 40;
  localparam logic [TIME_W-1:0] TRAVEL_SET [PHASES] = '{
    16'd4, 16'd1, 16'd0, 16'd17, 16'd65535, 16'd9, 16'd200, 16'd2, 16'd33, 16'd1
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  bmpc_in_t          in_data;
  logic              out_valid;
  logic              out_ready = 1'b0;
  bmpc_out_t         out_data;
  int unsigned       mismatches;
  int unsigned       pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned travel_writes = 0;
  int unsigned stall_cycles  = 0;
  logic        up_level      = 1'b0;
  logic        down_level    = 1'b0;

  blind_motor_position_controller_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  bmpc_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles with no item moving", stall_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input cmd_e cmd, input logic level);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= bmpc_in_t'{cmd, level};
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  task automatic press(input cmd_e btn, input logic level);
    send_item(btn, level);
    if (btn == CMD_UP) begin
      up_level = level;
    end else begin
      down_level = level;
    end
  endtask

  task automatic ticks(input int unsigned count);
    repeat (count) send_item(CMD_TICK, 1'($urandom_range(1)));
  endtask

  // hold valid low until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_travel(input logic [TIME_W-1:0] ms);
    cfg_we    <= 1'b1;
    cfg_wdata <= ms;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    travel_writes++;
  endtask

  // button event or unused code followed by a burst of ticks, repeated
  task automatic run_random(input int unsigned n_items, input int unsigned trav);
    int unsigned sent;
    int unsigned burst_max;
    int unsigned burst;
    int unsigned pick;
    logic        paused;
    logic        lvl;
    sent      = 0;
    paused    = 1'b0;
    burst_max = (2 * trav + 3 > MAX_BURST) ? MAX_BURST : 2 * trav + 3;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_item(CMD_NONE, 1'($urandom_range(1)));
      end else if (pick < 52) begin
        lvl = ($urandom_range(9) < 8) ? !up_level : up_level;
        press(CMD_UP, lvl);
      end else begin
        lvl = ($urandom_range(9) < 8) ? !down_level : down_level;
        press(CMD_DOWN, lvl);
      end
      burst = $urandom_range(burst_max);
      ticks(burst);
      sent += burst + 1;
      if (!paused && sent >= n_items / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 11;
    recv_idle_pct = 50;

    // reset travel time: stopped and halted ticks, unused code, button combos
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_NONE, 1'b0);
    send_item(CMD_NONE, 1'b1);
    press(CMD_DOWN, 1'b0);
    press(CMD_UP, 1'b1);
    ticks(2);
    press(CMD_DOWN, 1'b1);
    press(CMD_UP, 1'b0);
    ticks(1);
    press(CMD_UP, 1'b1);
    press(CMD_UP, 1'b0);
    press(CMD_DOWN, 1'b0);
    press(CMD_DOWN, 1'b1);
    ticks(1);
    press(CMD_UP, 1'b1);
    press(CMD_DOWN, 1'b0);
    press(CMD_UP, 1'b0);

    // shortest travel: saturate at both ends
    drain();
    write_travel(16'd1);
    press(CMD_UP, 1'b1);
    ticks(2);
    press(CMD_UP, 1'b0);
    press(CMD_DOWN, 1'b1);
    ticks(2);
    press(CMD_DOWN, 1'b0);

    // shorten the travel time in the middle of a move
    drain();
    write_travel(16'd20);
    press(CMD_UP, 1'b1);
    ticks(14);
    drain();
    write_travel(16'd6);
    ticks(2);
    press(CMD_UP, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 50;
      end else if (p < 6) begin
        send_idle_pct = 50;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      write_travel(TRAVEL_SET[p]);
      run_random(ITEMS_PER_PHASE, TRAVEL_SET[p]);
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d items over %0d travel-time settings, zero and full range included,",
             items_sent, travel_writes + 1);
    $display("with sender and receiver stalls in both balances and at full rate.");
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
